// ----- hdl/tdpd_pkg.sv -----
// shared types and constants for the type/data parameter decoder
// no dependencies; used by type_data_parameter_decoder
package tdpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 56;
  localparam int unsigned CountW = 3;
  localparam int unsigned Lanes  = ValueW / ByteW;

  // flag byte layout
  localparam int unsigned FlagTypeExt  = 7;
  localparam int unsigned FlagTypeHi   = 6;
  localparam int unsigned FlagTypeLo   = 4;
  localparam int unsigned FlagSizeExt  = 3;
  localparam int unsigned FlagSizeHi   = 2;
  localparam int unsigned FlagSizeLo   = 0;

  typedef enum logic [2:0] {
    PH_FLAG = 3'b001,
    PH_TYPE = 3'b010,
    PH_SIZE = 3'b100
  } phase_t;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    value_t type_value;
    value_t size_value;
    logic   truncated;
  } result_t;

endpackage

// ----- hdl/type_data_parameter_decoder.sv -----
// type/data parameter decoder: byte stream in, one word per decoded parameter out
// depends on tdpd_pkg
//
// usage
//   in_*  : one byte per word; in_tuser set means the buffer has ended and the
//           byte is ignored. a flag byte opens each parameter, followed by up to
//           seven little-endian type bytes and up to seven size bytes
//   out_* : one word per completed parameter; type and size values, with
//           out_tuser marking a parameter cut short by a buffer end
// throughput: one input word per cycle while in_tready is high, set by the
//   combinational state update (accumulator lane insert plus phase/count step)
// result path: a completed result word is registered into the result register,
//   or into the skid register while the receiver is not taking the held word
// stalls: the result register is backed by one skid register, so input keeps
//   flowing while a result waits; in_tready drops only when both are full and
//   returns the cycle after the receiver takes a word
// reset: rst_n low at a clock edge returns to expecting a flag byte with cleared
//   accumulators and discards any pending result words
module type_data_parameter_decoder (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tuser,   // [0] buffer_end
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [55:0] type_value, [111:56] size_value
  output logic         out_tuser   // [0] truncated
);

  // decoder state
  tdpd_pkg::phase_t phase_r, phase_nxt;
  tdpd_pkg::count_t bytes_left_r, bytes_left_nxt;
  tdpd_pkg::count_t byte_pos_r, byte_pos_nxt;
  logic [tdpd_pkg::ByteW-1:0] held_flag_r, held_flag_nxt;
  tdpd_pkg::value_t type_acc_r, type_acc_nxt;
  tdpd_pkg::value_t size_acc_r, size_acc_nxt;

  // result register and skid register
  logic              out_valid_r, skid_valid_r;
  tdpd_pkg::result_t out_data_r, skid_data_r;

  logic              in_fire, out_fire;
  logic              emit;
  tdpd_pkg::result_t res;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // next-state decode for one byte
  always_comb begin
    logic [tdpd_pkg::ByteW-1:0] b;
    logic [tdpd_pkg::ByteW-1:0] flag;
    tdpd_pkg::count_t           cnt;
    tdpd_pkg::count_t           left_dec;
    tdpd_pkg::value_t           lane_val;
    tdpd_pkg::value_t           cur_type;
    logic                       size_pending;

    b            = in_tdata;
    flag         = held_flag_r;
    cnt          = '0;
    left_dec     = bytes_left_r - tdpd_pkg::count_t'(1);
    lane_val     = '0;
    cur_type     = type_acc_r;
    size_pending = 1'b0;

    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    byte_pos_nxt   = byte_pos_r;
    held_flag_nxt  = held_flag_r;
    type_acc_nxt   = type_acc_r;
    size_acc_nxt   = size_acc_r;
    emit           = 1'b0;
    res.type_value = type_acc_r;
    res.size_value = size_acc_r;
    res.truncated  = 1'b0;

    // byte placed in its lane; position seven falls outside the value
    for (int i = 0; i < tdpd_pkg::Lanes; i++) begin
      if (byte_pos_r == tdpd_pkg::count_t'(i)) begin
        lane_val[i*tdpd_pkg::ByteW +: tdpd_pkg::ByteW] = b;
      end
    end

    unique case (phase_r)
      tdpd_pkg::PH_TYPE, tdpd_pkg::PH_SIZE: begin
        if (in_tuser) begin
          // buffer ran out mid-parameter
          emit          = 1'b1;
          res.truncated = 1'b1;
          if (phase_r == tdpd_pkg::PH_TYPE) begin
            res.size_value = flag[tdpd_pkg::FlagSizeExt] ? '0 :
              tdpd_pkg::value_t'(flag[tdpd_pkg::FlagSizeHi:tdpd_pkg::FlagSizeLo]);
          end
        end else begin
          byte_pos_nxt   = byte_pos_r + tdpd_pkg::count_t'(1);
          bytes_left_nxt = left_dec;
          if (phase_r == tdpd_pkg::PH_TYPE) begin
            type_acc_nxt = type_acc_r | lane_val;
            cur_type     = type_acc_r | lane_val;
            if (left_dec == '0) begin
              size_pending = 1'b1;
            end
          end else begin
            size_acc_nxt = size_acc_r | lane_val;
            if (left_dec == '0) begin
              emit           = 1'b1;
              res.size_value = size_acc_r | lane_val;
            end
          end
        end
      end
      default: begin
        // expecting a flag byte
        phase_nxt = tdpd_pkg::PH_FLAG;
        if (!in_tuser) begin
          held_flag_nxt = b;
          flag          = b;
          type_acc_nxt  = '0;
          size_acc_nxt  = '0;
          byte_pos_nxt  = '0;
          cnt           = b[tdpd_pkg::FlagTypeHi:tdpd_pkg::FlagTypeLo];
          if (b[tdpd_pkg::FlagTypeExt] && cnt != '0) begin
            phase_nxt      = tdpd_pkg::PH_TYPE;
            bytes_left_nxt = cnt;
          end else begin
            cur_type     = b[tdpd_pkg::FlagTypeExt] ? '0 : tdpd_pkg::value_t'(cnt);
            type_acc_nxt = cur_type;
            size_pending = 1'b1;
          end
        end
      end
    endcase

    // type done: open the size field or finish
    if (size_pending) begin
      cnt = flag[tdpd_pkg::FlagSizeHi:tdpd_pkg::FlagSizeLo];
      if (flag[tdpd_pkg::FlagSizeExt] && cnt != '0) begin
        phase_nxt      = tdpd_pkg::PH_SIZE;
        bytes_left_nxt = cnt;
        byte_pos_nxt   = '0;
        size_acc_nxt   = '0;
      end else begin
        emit           = 1'b1;
        res.type_value = cur_type;
        res.size_value = flag[tdpd_pkg::FlagSizeExt] ? '0 : tdpd_pkg::value_t'(cnt);
      end
    end

    // every result returns to an idle, cleared state
    if (emit) begin
      phase_nxt      = tdpd_pkg::PH_FLAG;
      bytes_left_nxt = '0;
      byte_pos_nxt   = '0;
      held_flag_nxt  = '0;
      type_acc_nxt   = '0;
      size_acc_nxt   = '0;
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tdpd_pkg::PH_FLAG;
      bytes_left_r <= '0;
      byte_pos_r   <= '0;
      held_flag_r  <= '0;
      type_acc_r   <= '0;
      size_acc_r   <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_pos_r   <= byte_pos_nxt;
      held_flag_r  <= held_flag_nxt;
      type_acc_r   <= type_acc_nxt;
      size_acc_r   <= size_acc_nxt;
    end
  end

  // result register with skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_fire) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire && emit) begin
        if (!out_valid_r || out_fire) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire && emit) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.size_value, out_data_r.type_value};
  assign out_tuser  = out_data_r.truncated;

  // skid only ever fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the result register is empty");

  // a result produced against a stalled receiver must land in the skid
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result word dropped while the receiver stalled");

  // idle phase always has its counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tdpd_pkg::PH_FLAG) |-> (bytes_left_r == '0 && byte_pos_r == '0))
    else $error("byte counters not cleared between parameters");

  // a byte-reading phase always has bytes left to read
  a_bytes_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != tdpd_pkg::PH_FLAG) |-> (bytes_left_r != '0))
    else $error("byte-reading phase with no bytes left");

endmodule
